>>> rtl/mcs_pkg.sv
// Shared types and constants for the moving-average crossover signal unit.
// No dependencies; mcs_div and the top level import this package, mcs_ram does not.
package mcs_pkg;

    // Field widths.
    localparam int PRICE_W  = 32;
    localparam int SIGNAL_W = 32;
    localparam int STATUS_W = 2;

    // Default window lengths.
    localparam int LONG_WINDOW_DEF  = 20;
    localparam int SHORT_WINDOW_DEF = 5;

    // Scaling: percent times Q16.16. The quotient keeps 34 bits, so anything
    // at or above 2^34 saturates before the division starts.
    localparam int PCT_SCALE = 100;
    localparam int PCT_W     = 7;
    localparam int FRAC_W    = 16;
    localparam int QUO_W     = 34;

    localparam logic [QUO_W-1:0] POS_LIMIT =
        {{(QUO_W-SIGNAL_W+1){1'b0}}, {(SIGNAL_W-1){1'b1}}};
    localparam logic [QUO_W-1:0] NEG_LIMIT =
        {{(QUO_W-SIGNAL_W){1'b0}}, 1'b1, {(SIGNAL_W-1){1'b0}}};

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_WARMUP = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_SHORT,
        ST_RD_LONG,
        ST_UPDATE,
        ST_EVAL,
        ST_SCALE,
        ST_DIFF,
        ST_PCT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } mcs_state_t;

    // Request from the sequencer to the divider.
    typedef struct packed {
        logic start;
        logic neg;
    } mcs_div_req_t;

endpackage

>>> rtl/mcs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 20
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/mcs_div.sv
// Radix-2 restoring divider that forms the saturated, signed Q16.16 percentage.
// Depends on mcs_pkg for widths, limits and the request struct.
module mcs_div #(
    parameter int DIVIDEND_W = 52,
    parameter int DIVISOR_W  = 44
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mcs_pkg::mcs_div_req_t         div_req,
    input  logic [DIVIDEND_W-1:0]         dividend,
    input  logic [DIVISOR_W-1:0]          divisor,
    output logic                          done,
    output logic [mcs_pkg::SIGNAL_W-1:0]  result
);
    import mcs_pkg::*;

    // The dividend is shifted left by FRAC_W before dividing; its bits from
    // LOW_A upward form the part that must stay below the divisor.
    localparam int LOW_A = QUO_W - FRAC_W;
    localparam int HI_W  = DIVIDEND_W - LOW_A;
    localparam int CMP_W = (HI_W > DIVISOR_W) ? HI_W : DIVISOR_W;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic                 neg_reg;
    logic                 sat_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [QUO_W-1:0]     low_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic [SIGNAL_W-1:0]  result_reg;

    logic [HI_W-1:0]      hi;
    logic                 start_sat;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   trial_diff;
    logic                 trial_ge;
    logic [QUO_W-1:0]     limit;
    logic [QUO_W-1:0]     mag;
    logic [SIGNAL_W-1:0]  mag_s;

    assign hi        = dividend[DIVIDEND_W-1:LOW_A];
    assign start_sat = CMP_W'(hi) >= CMP_W'(divisor);

    assign trial      = {rem_reg, low_reg[QUO_W-1]};
    assign trial_ge   = trial >= {1'b0, dvs_reg};
    assign trial_diff = trial - {1'b0, dvs_reg};

    assign limit = neg_reg ? NEG_LIMIT : POS_LIMIT;
    assign mag   = (sat_reg || (quo_reg > limit)) ? limit : quo_reg;
    assign mag_s = mag[SIGNAL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (div_req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= start_sat ? '0 : CNT_W'(QUO_W);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div_req.start) begin
            neg_reg <= div_req.neg;
            sat_reg <= start_sat;
            dvs_reg <= divisor;
            rem_reg <= start_sat ? '0 : DIVISOR_W'(hi);
            low_reg <= {dividend[LOW_A-1:0], {FRAC_W{1'b0}}};
            quo_reg <= '0;
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                rem_reg <= trial_ge ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
                low_reg <= {low_reg[QUO_W-2:0], 1'b0};
                quo_reg <= {quo_reg[QUO_W-2:0], trial_ge};
            end else begin
                result_reg <= neg_reg ? (SIGNAL_W'(0) - mag_s) : mag_s;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/ma_crossover_signal_unit.sv
// Top level of the moving-average crossover signal unit.
// Depends on mcs_pkg, mcs_ram (price ring) and mcs_div (scaled divider).
//
// The unit takes one closing price per input transaction (unsigned Q16.16,
// with an unavailable flag and a series-start flag) and returns exactly one
// result transaction per input: the percentage by which the short moving
// average exceeds the long one, as signed Q16.16, truncated toward zero and
// saturated to 32 bits, with a status of 0 (valid), 1 (fewer than
// LONG_WINDOW available prices since the series start) or 2 (long sum zero).
// The LONG_WINDOW most recent available prices live in a small synchronous
// RAM; each available price costs two ring reads and one write, done as a
// read-modify-write sequence on the running short and long sums. A series
// start clears the counts and sums; its price is never counted. An
// unavailable price leaves the history alone but still yields a result from
// the earlier data. The unit works on one transaction at a time: a priced
// transaction with a full window goes through the two ring reads and the
// write, then evaluation, scaling, the difference and the percentage, then
// a state that starts the divider and the wait on the radix-2 divider,
// which produces one quotient bit per cycle and then forms the saturated
// result and reports done, and last the load of the output register. An
// unavailable price with a full window skips the ring, and a quotient that
// is known to saturate skips the divider steps. Transactions that finish
// with status 1 or 2 skip scaling and the divider, and also skip the ring
// when the price is unavailable or starts a series. The
// result sits in an output register, so s_ready returns in the cycle after
// the result is loaded, even while m_ready is held low; a further result
// then waits in its last state until the output register is free.
module ma_crossover_signal_unit #(
    parameter int LONG_WINDOW  = mcs_pkg::LONG_WINDOW_DEF,
    parameter int SHORT_WINDOW = mcs_pkg::SHORT_WINDOW_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [mcs_pkg::PRICE_W-1:0]         s_price,
    input  logic                                s_unavailable,
    input  logic                                s_series_start,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [mcs_pkg::SIGNAL_W-1:0] m_signal,
    output logic [mcs_pkg::STATUS_W-1:0]        m_status
);
    import mcs_pkg::*;

    localparam int SLW  = $clog2(LONG_WINDOW);
    localparam int CNTW = $clog2(LONG_WINDOW + 1);
    localparam int SSW  = PRICE_W + $clog2(SHORT_WINDOW + 1);
    localparam int LSW  = PRICE_W + $clog2(LONG_WINDOW + 1);
    localparam int NUMW = SSW + $clog2(LONG_WINDOW + 1);
    localparam int DENW = LSW + $clog2(SHORT_WINDOW + 1);
    localparam int AW   = (NUMW > DENW) ? NUMW : DENW;
    localparam int A1W  = AW + PCT_W;
    localparam int SOFF = SHORT_WINDOW % LONG_WINDOW;

    mcs_state_t state_reg, state_next;

    logic [PRICE_W-1:0]  price_reg;
    logic [SLW-1:0]      slot_reg;
    logic [CNTW-1:0]     count_reg;
    logic [SSW-1:0]      short_sum_reg;
    logic [LSW-1:0]      long_sum_reg;
    logic [PRICE_W-1:0]  old_short_reg;
    logic [AW-1:0]       num_reg;
    logic [DENW-1:0]     den_reg;
    logic [AW-1:0]       a_reg;
    logic                neg_reg;
    logic [A1W-1:0]      a100_reg;
    logic [SIGNAL_W-1:0] sig_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                m_valid_reg;
    logic [SIGNAL_W-1:0] m_signal_reg;
    logic [STATUS_W-1:0] m_status_reg;

    // Control decoded from the state.
    logic          accept;
    logic          ram_rd_en;
    logic          ram_wr_en;
    logic          out_free;
    logic          out_load;
    mcs_div_req_t  div_req;

    logic [PRICE_W-1:0]  ram_rd_data;
    logic [SLW-1:0]      ram_rd_addr;
    logic [SLW:0]        short_idx_wide;
    logic [SLW-1:0]      short_addr;
    logic                short_full;
    logic                long_full;
    logic [SSW-1:0]      short_sum_next;
    logic [LSW-1:0]      long_sum_next;
    logic [SLW-1:0]      slot_next;
    logic                warmup;
    logic                div_done;
    logic [SIGNAL_W-1:0] div_result;

    // Ring slot that drops out of the short window on this write.
    assign short_idx_wide = (slot_reg >= SLW'(SOFF))
                          ? ({1'b0, slot_reg} - (SLW+1)'(SOFF))
                          : ({1'b0, slot_reg} + (SLW+1)'(LONG_WINDOW - SOFF));
    assign short_addr  = short_idx_wide[SLW-1:0];
    assign ram_rd_addr = (state_reg == ST_RD_SHORT) ? short_addr : slot_reg;

    assign short_full = 32'(count_reg) >= SHORT_WINDOW;
    assign long_full  = 32'(count_reg) >= LONG_WINDOW;
    assign warmup     = 32'(count_reg) < LONG_WINDOW;

    // Read data in ST_UPDATE is the entry about to be overwritten.
    assign short_sum_next = short_sum_reg - (short_full ? SSW'(old_short_reg) : SSW'(0))
                          + SSW'(price_reg);
    assign long_sum_next  = long_sum_reg - (long_full ? LSW'(ram_rd_data) : LSW'(0))
                          + LSW'(price_reg);
    assign slot_next      = (32'(slot_reg) == LONG_WINDOW - 1) ? '0 : slot_reg + 1'b1;

    assign out_free = !m_valid_reg || m_ready;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_series_start || s_unavailable) begin
                        state_next = ST_EVAL;
                    end else begin
                        state_next = ST_RD_SHORT;
                    end
                end
            end
            ST_RD_SHORT:  state_next = ST_RD_LONG;
            ST_RD_LONG:   state_next = ST_UPDATE;
            ST_UPDATE:    state_next = ST_EVAL;
            ST_EVAL: begin
                if (warmup || (long_sum_reg == '0)) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:     state_next = ST_DIFF;
            ST_DIFF:      state_next = ST_PCT;
            ST_PCT:       state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        s_ready       = 1'b0;
        ram_rd_en     = 1'b0;
        ram_wr_en     = 1'b0;
        out_load      = 1'b0;
        div_req.start = 1'b0;
        div_req.neg   = neg_reg;
        case (state_reg)
            ST_IDLE:      s_ready = 1'b1;
            ST_RD_SHORT:  ram_rd_en = 1'b1;
            ST_RD_LONG:   ram_rd_en = 1'b1;
            ST_UPDATE:    ram_wr_en = 1'b1;
            ST_DIV_START: div_req.start = 1'b1;
            ST_OUT:       out_load = out_free;
            default: begin
            end
        endcase
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            count_reg     <= '0;
            short_sum_reg <= '0;
            long_sum_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept && s_series_start) begin
                slot_reg      <= '0;
                count_reg     <= '0;
                short_sum_reg <= '0;
                long_sum_reg  <= '0;
            end else if (state_reg == ST_UPDATE) begin
                slot_reg      <= slot_next;
                short_sum_reg <= short_sum_next;
                long_sum_reg  <= long_sum_next;
                if (warmup) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            price_reg <= s_price;
        end
        if (state_reg == ST_RD_LONG) begin
            old_short_reg <= ram_rd_data;
        end
        if (state_reg == ST_EVAL) begin
            sig_reg    <= '0;
            status_reg <= warmup ? STATUS_WARMUP : STATUS_ZERO;
        end
        if (state_reg == ST_SCALE) begin
            num_reg <= AW'(short_sum_reg) * AW'(LONG_WINDOW);
            den_reg <= DENW'(long_sum_reg) * DENW'(SHORT_WINDOW);
        end
        if (state_reg == ST_DIFF) begin
            neg_reg <= num_reg < AW'(den_reg);
            a_reg   <= (num_reg < AW'(den_reg)) ? (AW'(den_reg) - num_reg)
                                                : (num_reg - AW'(den_reg));
        end
        if (state_reg == ST_PCT) begin
            a100_reg <= A1W'(a_reg) * A1W'(PCT_SCALE);
        end
        if ((state_reg == ST_DIV_WAIT) && div_done) begin
            sig_reg    <= div_result;
            status_reg <= STATUS_OK;
        end
        if (out_load) begin
            m_signal_reg <= sig_reg;
            m_status_reg <= status_reg;
        end
    end

    mcs_ram #(
        .WIDTH (PRICE_W),
        .DEPTH (LONG_WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_reg),
        .wr_data (price_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    mcs_div #(
        .DIVIDEND_W (A1W),
        .DIVISOR_W  (DENW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .div_req  (div_req),
        .dividend (a100_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .result   (div_result)
    );

    assign m_valid  = m_valid_reg;
    assign m_signal = m_signal_reg;
    assign m_status = m_status_reg;

endmodule

>>> tb/ma_crossover_signal_unit_tb.sv
// Self-checking testbench for the moving-average crossover signal unit.
// Depends on mcs_pkg and on ma_crossover_signal_unit with its submodules.
// Directed and random price streams run under several idling patterns.
module ma_crossover_signal_unit_tb;

    import mcs_pkg::*;

    localparam int LONG_LEN       = LONG_WINDOW_DEF;
    localparam int SHORT_LEN      = SHORT_WINDOW_DEF;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 64;
    localparam int MAX_REPORTS    = 10;
    localparam int TIMEOUT        = 5_000_000;

    // One expected result transaction, as the result channel carries it.
    typedef struct packed {
        logic [SIGNAL_W-1:0] signal;
        logic [STATUS_W-1:0] status;
    } signal_result_t;

    // Shapes of random price series. A new shape is picked at each series start.
    typedef enum int {
        STYLE_WIDE,
        STYLE_LEVEL,
        STYLE_SMALL,
        STYLE_HIGH,
        STYLE_SPARSE
    } price_style_t;

    logic                       aclk           = 1'b0;
    logic                       aresetn        = 1'b0;
    logic                       s_valid        = 1'b0;
    logic                       s_ready;
    logic [PRICE_W-1:0]         s_price        = '0;
    logic                       s_unavailable  = 1'b0;
    logic                       s_series_start = 1'b0;
    logic                       m_valid;
    logic                       m_ready        = 1'b0;
    logic signed [SIGNAL_W-1:0] m_signal;
    logic [STATUS_W-1:0]        m_status;

    // Expected results in the order their input transactions were accepted.
    signal_result_t pending_signals[$];
    int             mismatch_count = 0;
    int             result_index   = 0;

    // Idling controls. The sender's percentage is only read by the main
    // process; the receiver's is changed with a nonblocking assignment so the
    // receiver process never races the change.
    int  src_idle_pct   = 0;
    int  sink_stall_pct = 0;
    logic holdoff_active = 1'b0;
    event start_holdoff;

    // Predictor state: the ring of available prices and its running sums.
    logic [PRICE_W-1:0] hist_prices [LONG_LEN] = '{default: '0};
    int unsigned        hist_wr     = 0;
    int unsigned        hist_count  = 0;
    logic [63:0]        short_total = '0;
    logic [63:0]        long_total  = '0;

    // State of the random price generator.
    price_style_t       price_style = STYLE_LEVEL;
    logic [PRICE_W-1:0] base_price  = 32'h0064_0000;

    ma_crossover_signal_unit i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_price        (s_price),
        .s_unavailable  (s_unavailable),
        .s_series_start (s_series_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_signal       (m_signal),
        .m_status       (m_status)
    );

    always #5 aclk = ~aclk;

    // Advances the predicted ring by one input transaction and returns the
    // result the unit must produce for it. A series start clears everything
    // and its price is dropped; an unavailable price leaves the ring alone.
    // The signal is floor(|20*s5 - 5*s20| * 100 * 2^16 / (5*s20)), clamped to
    // the signed 32-bit range and then given the sign of the difference.
    function automatic signal_result_t predict_crossover(
        input logic [PRICE_W-1:0] price,
        input logic               unavail,
        input logic               start
    );
        signal_result_t res;
        logic [127:0]   num;
        logic [127:0]   den;
        logic [127:0]   diff;
        logic [127:0]   mag;
        logic [127:0]   lim;
        logic           neg;
        if (start) begin
            foreach (hist_prices[i]) hist_prices[i] = '0;
            hist_wr     = 0;
            hist_count  = 0;
            short_total = '0;
            long_total  = '0;
        end else if (!unavail) begin
            // The oldest entry of each window drops out once that window is full.
            if (hist_count >= SHORT_LEN) begin
                short_total -= hist_prices[(hist_wr + LONG_LEN - SHORT_LEN) % LONG_LEN];
            end
            if (hist_count >= LONG_LEN) begin
                long_total -= hist_prices[hist_wr];
            end
            hist_prices[hist_wr] = price;
            short_total += price;
            long_total  += price;
            hist_wr = (hist_wr + 1) % LONG_LEN;
            if (hist_count < LONG_LEN) hist_count++;
        end
        res.signal = '0;
        if (hist_count < LONG_LEN) begin
            res.status = STATUS_WARMUP;
        end else if (long_total == 0) begin
            res.status = STATUS_ZERO;
        end else begin
            num  = 128'(LONG_LEN) * short_total;
            den  = 128'(SHORT_LEN) * long_total;
            neg  = (num < den);
            diff = neg ? den - num : num - den;
            mag  = diff * 128'(PCT_SCALE) * (128'd1 << FRAC_W) / den;
            lim  = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
            if (mag > lim) mag = lim;
            res.signal = neg ? -mag[SIGNAL_W-1:0] : mag[SIGNAL_W-1:0];
            res.status = STATUS_OK;
        end
        return res;
    endfunction

    // Receiver. Outside a hold-off it stalls at random with the current
    // percentage; during a hold-off m_ready stays low so that the unit's
    // output register fills and its input stalls.
    always @(posedge aclk) begin
        if (holdoff_active) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // The hold-off length is counted here, in cycles, separate from both the
    // receiver and the sender.
    always begin
        @(start_holdoff);
        holdoff_active <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge aclk);
        holdoff_active <= 1'b0;
    end

    // Result checker. Every accepted result transaction is compared with the
    // oldest expectation; results with nothing waiting count as failures too.
    always @(posedge aclk) begin : check_results
        signal_result_t oldest;
        if (aresetn && m_valid && m_ready) begin
            if (pending_signals.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("ERROR: result %0d arrived with nothing expected: signal %0d status %0d",
                             result_index, m_signal, m_status);
                end
            end else begin
                oldest = pending_signals.pop_front();
                if (m_signal !== oldest.signal || m_status !== oldest.status) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("ERROR: result %0d: signal expected %0d got %0d, status expected %0d got %0d",
                                 result_index, $signed(oldest.signal), m_signal,
                                 oldest.status, m_status);
                    end
                end
            end
            result_index++;
        end
    end

    // Sends one input transaction. Random idle cycles come first, with valid
    // low; valid is never lowered after an acceptance here, so back-to-back
    // transactions keep it high without a second assignment in one step. The
    // expectation is recorded at the edge where the transaction is accepted.
    task automatic send_item(
        input logic [PRICE_W-1:0] price,
        input logic               unavail,
        input logic               start
    );
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_price        <= price;
        s_unavailable  <= unavail;
        s_series_start <= start;
        do @(posedge aclk); while (!s_ready);
        pending_signals.push_back(predict_crossover(price, unavail, start));
    endtask

    // Lowers valid and waits until every expected result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_signals.size() != 0) @(posedge aclk);
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct = src_pct;
        sink_stall_pct <= sink_pct;
    endtask

    // Random price stream. Most transactions extend a series of one shape,
    // so that windows fill and the signal is exercised; occasional series
    // starts cut windows short and unavailable prices punch holes in them.
    task automatic run_random_items(input int count);
        logic [PRICE_W-1:0] price;
        logic               unavail;
        logic               start;
        for (int n = 0; n < count; n++) begin
            start   = ($urandom_range(99) < 2);
            unavail = start ? 1'($urandom_range(1)) : ($urandom_range(99) < 10);
            if (start) begin
                price_style = price_style_t'($urandom_range(int'(STYLE_SPARSE)));
                base_price  = $urandom();
            end
            case (price_style)
                STYLE_WIDE: begin
                    price = $urandom();
                end
                STYLE_LEVEL: begin
                    price = base_price + $urandom_range(262143) - 32'd131072;
                end
                STYLE_SMALL: begin
                    price = $urandom_range(255);
                end
                STYLE_HIGH: begin
                    price = 32'hFFFF_FFFF - $urandom_range(1023);
                end
                default: begin
                    // Mostly zero prices: yields all-zero windows and empty
                    // short windows next to an occasional large price.
                    price = ($urandom_range(9) == 0) ? $urandom() : 32'd0;
                end
            endcase
            send_item(price, unavail, start);
        end
    endtask

    // A window of zero prices has a zero long sum; an unavailable price after
    // it must still report that status from the stored data.
    task automatic test_zero_long_sum();
        set_idling(0, 0);
        for (int n = 0; n < LONG_LEN; n++) send_item(32'd0, 1'b0, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b1, 1'b0);
        drain_results();
    endtask

    // A full-scale price lands entirely in the short window, giving the
    // largest positive signal. Series starts then restart the warm-up whatever
    // the other fields say, and the next priced transaction is counted again.
    task automatic test_full_scale_and_restart();
        set_idling(0, 0);
        send_item(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b1, 1'b1);
        send_item(32'h7FFF_FFFF, 1'b0, 1'b1);
        send_item(32'h8000_0000, 1'b0, 1'b0);
        drain_results();
    endtask

    task automatic test_random_no_idle();
        set_idling(0, 0);
        run_random_items(150);
        drain_results();
    endtask

    task automatic test_random_sender_idle();
        set_idling(70, 0);
        run_random_items(120);
        drain_results();
    endtask

    task automatic test_random_receiver_stall();
        set_idling(0, 70);
        run_random_items(120);
        drain_results();
    endtask

    task automatic test_random_both_idle();
        set_idling(10, 10);
        run_random_items(100);
        drain_results();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering transactions back to back, so the unit fills up and holds
    // s_ready low until results drain again.
    task automatic test_output_backpressure();
        set_idling(0, 0);
        -> start_holdoff;
        run_random_items(12);
        drain_results();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_zero_long_sum();
        test_full_scale_and_restart();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_output_backpressure();

        // Any stray result after the last expected one is caught by the checker.
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog: a hang or a result that never arrives ends the run here.
    initial begin
        #(TIMEOUT);
        $display("Test completed with failures");
        $finish;
    end

endmodule
